// ===== hw/rtl/sync_word_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer RTL.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define SWFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swfd_pkg.sv =====
package swfd_pkg;

  localparam int unsigned DataBytes = 12;
  localparam int unsigned NumValues = 6;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned ValuesW   = NumValues * ValueW;

  localparam logic [3:0] SyncLen   = 4'd4;
  localparam logic [3:0] SkipLen   = 4'd12;
  localparam logic [3:0] FrameLast = 4'd15;

  localparam logic [7:0] SyncFf = 8'hFF;
  localparam logic [7:0] Sync00 = 8'h00;

  localparam logic [7:0] SyncPattern [4] = '{SyncFf, SyncFf, SyncFf, Sync00};

  typedef struct packed {
    logic               emit;
    logic               frame_error;
    logic [ValuesW-1:0] values;
  } result_t;

endpackage

// ===== hw/rtl/swfd_core.sv =====
`include "sync_word_frame_deframer_assert.svh"

module swfd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output swfd_pkg::result_t result_o
);

  localparam logic [1:0] ModeAligned = 2'd0;
  localparam logic [1:0] ModeHunt    = 2'd1;
  localparam logic [1:0] ModeSkip    = 2'd2;

  logic [1:0] mode_q, mode_d;
  logic [1:0] hunt_q, hunt_d;
  logic [3:0] count_q, count_d;
  logic       sync_ok_q, sync_ok_d;

  logic [7:0] data_q [swfd_pkg::DataBytes];
  logic [7:0] frame  [swfd_pkg::DataBytes];
  logic       wr_en;
  logic [3:0] wr_idx;
  logic [3:0] count_inc;
  logic [swfd_pkg::ValuesW-1:0] values;

  assign count_inc = 4'(count_q + 4'd1);
  assign wr_idx    = 4'(count_q - swfd_pkg::SyncLen);

  // The last data byte comes straight from the input at the end of a frame.
  always_comb begin
    for (int k = 0; k < swfd_pkg::DataBytes; k++) begin
      frame[k] = data_q[k];
    end
    frame[swfd_pkg::DataBytes-1] = rx_byte_i;
    for (int i = 0; i < swfd_pkg::NumValues; i++) begin
      values[i*swfd_pkg::ValueW +: swfd_pkg::ValueW] = {frame[2*i+1], frame[2*i]};
    end
  end

  always_comb begin
    mode_d    = mode_q;
    hunt_d    = hunt_q;
    count_d   = count_q;
    sync_ok_d = sync_ok_q;
    wr_en     = 1'b0;
    result_o  = '0;
    unique case (mode_q)
      ModeHunt: begin
        if (rx_byte_i == swfd_pkg::SyncFf) begin
          if (hunt_q != 2'd3) begin
            hunt_d = 2'(hunt_q + 2'd1);
          end
        end else if (rx_byte_i == swfd_pkg::Sync00 && hunt_q == 2'd3) begin
          hunt_d  = 2'd0;
          mode_d  = ModeSkip;
          count_d = 4'd0;
        end else begin
          hunt_d = 2'd0;
        end
      end
      ModeSkip: begin
        count_d = count_inc;
        if (count_inc >= swfd_pkg::SkipLen) begin
          mode_d               = ModeAligned;
          count_d              = 4'd0;
          sync_ok_d            = 1'b1;
          result_o.emit        = 1'b1;
          result_o.frame_error = 1'b1;
        end
      end
      default: begin
        mode_d = ModeAligned;
        if (count_q < swfd_pkg::SyncLen) begin
          if (rx_byte_i != swfd_pkg::SyncPattern[count_q[1:0]]) begin
            sync_ok_d = 1'b0;
          end
        end else begin
          wr_en = 1'b1;
        end
        if (count_q == swfd_pkg::FrameLast) begin
          count_d = 4'd0;
          if (sync_ok_q) begin
            result_o.emit   = 1'b1;
            result_o.values = values;
          end else begin
            sync_ok_d = 1'b1;
            mode_d    = ModeHunt;
            hunt_d    = 2'd0;
          end
        end else begin
          count_d = count_inc;
        end
      end
    endcase
    if (!accept_i) begin
      mode_d        = mode_q;
      hunt_d        = hunt_q;
      count_d       = count_q;
      sync_ok_d     = sync_ok_q;
      wr_en         = 1'b0;
      result_o.emit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeAligned;
      hunt_q    <= 2'd0;
      count_q   <= 4'd0;
      sync_ok_q <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      hunt_q    <= hunt_d;
      count_q   <= count_d;
      sync_ok_q <= sync_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_q[wr_idx] <= rx_byte_i;
    end
  end

  `SWFD_ASSERT_IMPL(a_hunt_count_zero, mode_q == ModeHunt, count_q == 4'd0, "hunt with count")
  `SWFD_ASSERT_IMPL(a_skip_count_range, mode_q == ModeSkip, count_q < swfd_pkg::SkipLen,
                    "skip count out of range")
  `SWFD_ASSERT_IMPL(a_error_from_skip, result_o.emit && result_o.frame_error,
                    mode_q == ModeSkip, "error result outside skip")
  `SWFD_ASSERT_NEXT(a_bad_frame_hunts,
                    accept_i && mode_q == ModeAligned && count_q == swfd_pkg::FrameLast
                    && !sync_ok_q, mode_q == ModeHunt && sync_ok_q, "bad frame did not hunt")

endmodule

// ===== hw/rtl/sync_word_frame_deframer.sv =====
// A result is valid in the cycle after the transaction of the frame's last byte.
// Throughput: one byte per cycle; a byte is taken whenever the result register is free
// or is being drained in the same cycle.
// Reset (rst_ni low, asynchronous): aligned to a frame start, no result pending.
`include "sync_word_frame_deframer_assert.svh"

module sync_word_frame_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // value0..value5, 16 bits each, value0 lowest
  output logic [0:0]   m_axis_tuser   // [0] frame_error
);

  logic                            accept;
  swfd_pkg::result_t               result;
  logic                            out_valid_q;
  logic [swfd_pkg::ValuesW-1:0]    out_values_q;
  logic                            out_error_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  swfd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.emit) begin
      out_values_q <= result.values;
      out_error_q  <= result.frame_error;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_values_q;
  assign m_axis_tuser  = out_error_q;

  `SWFD_ASSERT_IMPL(a_error_values_zero, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tdata == '0, "error result carries data")
  `SWFD_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, out_valid_q,
                    "input stalled with empty result register")
  `SWFD_ASSERT_NEXT(a_emit_sets_valid, result.emit, out_valid_q,
                    "result lost")

endmodule

// ===== tb/swfd_frame_checker.sv =====
`timescale 1ns / 100ps

module swfd_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [swfd_pkg::ValuesW-1:0] m_axis_tdata,   // value0..value5, 16 bits each, value0 lowest
  input  logic [0:0]                   m_axis_tuser,   // [0] frame_error
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef enum logic [1:0] {
    RxAligned = 2'd0,
    RxHunt    = 2'd1,
    RxSkip    = 2'd2
  } rx_mode_e;

  typedef struct packed {
    logic                         frame_error;
    logic [swfd_pkg::ValuesW-1:0] values;
  } frame_result_t;

  rx_mode_e      rx_mode = RxAligned;
  logic [1:0]    ff_run = '0;
  logic [3:0]    frame_pos = '0;
  logic          sync_match = 1'b1;
  logic [7:0]    sample_bytes [swfd_pkg::DataBytes];
  frame_result_t expected_frames_q [$];
  int            mismatches = 0;

  task automatic report_mismatch(input string what,
                                 input logic [swfd_pkg::ValuesW-1:0] got,
                                 input logic [swfd_pkg::ValuesW-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void predict_rx_byte(input logic [7:0] rx);
    frame_result_t r;
    r = '0;
    case (rx_mode)
      RxHunt: begin
        if (rx == swfd_pkg::SyncFf) begin
          if (ff_run != 2'd3) ff_run = ff_run + 2'd1;
        end else if (rx == swfd_pkg::Sync00 && ff_run == 2'd3) begin
          ff_run    = '0;
          rx_mode   = RxSkip;
          frame_pos = '0;
        end else begin
          ff_run = '0;
        end
      end
      RxSkip: begin
        frame_pos = frame_pos + 4'd1;
        if (frame_pos >= swfd_pkg::SkipLen) begin
          rx_mode       = RxAligned;
          frame_pos     = '0;
          sync_match    = 1'b1;
          r.frame_error = 1'b1;
          expected_frames_q.push_back(r);
        end
      end
      default: begin
        rx_mode = RxAligned;
        if (frame_pos < swfd_pkg::SyncLen) begin
          if (rx != swfd_pkg::SyncPattern[frame_pos[1:0]]) sync_match = 1'b0;
        end else begin
          sample_bytes[frame_pos - swfd_pkg::SyncLen] = rx;
        end
        if (frame_pos == swfd_pkg::FrameLast) begin
          frame_pos = '0;
          if (sync_match) begin
            for (int i = 0; i < swfd_pkg::NumValues; i++) begin
              r.values[i*swfd_pkg::ValueW +: swfd_pkg::ValueW] =
                {sample_bytes[2*i+1], sample_bytes[2*i]};
            end
            expected_frames_q.push_back(r);
          end else begin
            sync_match = 1'b1;
            rx_mode    = RxHunt;
            ff_run     = '0;
          end
        end else begin
          frame_pos = frame_pos + 4'd1;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    frame_result_t want;
    if (!rst_ni) begin
      rx_mode    = RxAligned;
      ff_run     = '0;
      frame_pos  = '0;
      sync_match = 1'b1;
      expected_frames_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_frames_q.size() == 0) begin
          report_mismatch("result with no frame pending", m_axis_tdata, '0);
        end else begin
          want = expected_frames_q.pop_front();
          for (int i = 0; i < swfd_pkg::NumValues; i++) begin
            if (m_axis_tdata[i*swfd_pkg::ValueW +: swfd_pkg::ValueW] !==
                want.values[i*swfd_pkg::ValueW +: swfd_pkg::ValueW]) begin
              report_mismatch($sformatf("value%0d", i),
                  swfd_pkg::ValuesW'(m_axis_tdata[i*swfd_pkg::ValueW +: swfd_pkg::ValueW]),
                  swfd_pkg::ValuesW'(want.values[i*swfd_pkg::ValueW +: swfd_pkg::ValueW]));
            end
          end
          if (m_axis_tuser[0] !== want.frame_error) begin
            report_mismatch("frame_error", swfd_pkg::ValuesW'(m_axis_tuser[0]),
                            swfd_pkg::ValuesW'(want.frame_error));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_rx_byte(s_axis_tdata);
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_frames_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0] DirectedBytes [54] = '{
    8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
    8'h55, 8'hAA, 8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE, 8'h7F,
    8'h00, 8'hFF, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
    8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'h00,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'hA5, 8'h5A, 8'h3C, 8'hC3
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;   // [7:0] rx_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [swfd_pkg::ValuesW-1:0] m_axis_tdata;        // value0..value5, 16 bits each, value0 lowest
  logic [0:0]                   m_axis_tuser;        // [0] frame_error

  logic idle_en = 1'b0;
  int   ready_hold = 0;
  int   bytes_sent = 0;
  int   fail_count;
  int   pending;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sync_word_frame_deframer uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  swfd_frame_checker checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return swfd_pkg::SyncFf;
      1:       return swfd_pkg::Sync00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_rx_byte(input logic [7:0] rx);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit corrupt);
    int         bad_pos;
    logic [7:0] rx;
    bad_pos = corrupt ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 16; i++) begin
      if (i < 4) begin
        rx = swfd_pkg::SyncPattern[i];
        if (i == bad_pos) rx = rx ^ 8'($urandom_range(1, 255));
      end else begin
        rx = rand_byte();
      end
      send_rx_byte(rx);
    end
  endtask

  task automatic send_resync();
    repeat ($urandom_range(0, 8)) send_rx_byte(rand_byte());
    repeat ($urandom_range(3, 5)) send_rx_byte(swfd_pkg::SyncFf);
    send_rx_byte(swfd_pkg::Sync00);
    repeat (12) send_rx_byte(rand_byte());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_en <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedBytes[i]) send_rx_byte(DirectedBytes[i]);

    // hold off until every frame so far has drained
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    while (bytes_sent < 850) begin
      if ($urandom_range(0, 7) == 0) idle_en <= ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        7, 8: begin
          send_frame(1'b1);
          send_resync();
        end
        9: repeat ($urandom_range(1, 15)) send_rx_byte(8'($urandom_range(0, 255)));
        default: send_frame(1'b0);
      endcase
    end

    idle_en <= 1'b0;
    send_frame(1'b1);
    send_resync();
    repeat (8) send_frame(1'b0);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/swfd_pkg.sv
hw/rtl/swfd_core.sv
hw/rtl/sync_word_frame_deframer.sv
tb/swfd_frame_checker.sv
tb/tb.sv
